>>> src/hkv_pkg.sv
// Shared types, constants and sizes of the hashed key-value map.
package hkv_pkg;

    localparam int NUM_BUCKETS      = 16;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Bucket index is the low key bits, so NUM_BUCKETS stays a power of two.
    localparam int BUCKET_W = $clog2(NUM_BUCKETS);
    localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_DELETE,
        OP_NOP
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [SLOT_W-1:0]   slot_idx_t;

    typedef logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0]   key_row_t;
    typedef logic [SLOTS_PER_BUCKET-1:0][VALUE_W-1:0] value_row_t;
    typedef logic [SLOTS_PER_BUCKET-1:0]              valid_row_t;

    typedef struct packed {
        op_t                 op;
        bucket_t             bucket;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } request_t;

endpackage

>>> src/hkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/hkv_front.sv
// Front end: accepts requests, decodes the operation and bucket, queues them.
module hkv_front
    import hkv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    output logic                req_valid,
    input  logic                req_ready,
    output request_t            req
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    request_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    request_t           decoded;
    logic               push, pop;

    always_comb
    begin
        decoded.bucket = key[BUCKET_W-1:0];
        decoded.key    = key;
        decoded.value  = value;
        case (mode)
            MODE_INSERT: decoded.op = OP_INSERT;
            MODE_SEARCH: decoded.op = OP_SEARCH;
            MODE_DELETE: decoded.op = OP_DELETE;
            default:     decoded.op = OP_NOP;
        endcase
    end

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

>>> src/hkv_back.sv
// Back end: reads a bucket row, matches keys, writes the row back, drives results.
module hkv_back
    import hkv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  request_t             req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [VALUE_W-1:0]   read_value,
    output logic [STATUS_W-1:0]  status
);

    back_state_t           state_reg, state_next;
    request_t              cur_reg;
    valid_row_t            valid_reg [NUM_BUCKETS];

    logic                  out_valid_reg;
    logic                  hit_reg, hit_next;
    logic [VALUE_W-1:0]    read_value_reg, read_value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  rd_en;
    logic                  load_out;
    key_row_t              key_rd, key_wr;
    value_row_t            value_rd, value_wr;
    valid_row_t            valid_row, valid_row_next;
    logic                  row_wr_en;
    logic                  found, free_found;
    slot_idx_t             match_idx, free_idx, wr_idx;

    hkv_ram #(
        .WIDTH ($bits(key_row_t)),
        .DEPTH (NUM_BUCKETS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (cur_reg.bucket),
        .wr_data (key_wr),
        .rd_en   (rd_en),
        .rd_addr (req.bucket),
        .rd_data (key_rd)
    );

    hkv_ram #(
        .WIDTH ($bits(value_row_t)),
        .DEPTH (NUM_BUCKETS)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (cur_reg.bucket),
        .wr_data (value_wr),
        .rd_en   (rd_en),
        .rd_addr (req.bucket),
        .rd_data (value_rd)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        req_ready = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            BK_IDLE: req_ready = 1'b1;
            BK_EXEC: load_out  = !out_valid_reg || out_ready;
            default: req_ready = 1'b0;
        endcase
    end

    assign rd_en     = req_valid && req_ready;
    assign valid_row = valid_reg[cur_reg.bucket];

    // Slot match and lowest free slot, all slots compared at once
    always_comb
    begin
        found      = 1'b0;
        free_found = 1'b0;
        match_idx  = '0;
        free_idx   = '0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (valid_row[s])
            begin
                if (!found && key_rd[s] == cur_reg.key)
                begin
                    found     = 1'b1;
                    match_idx = SLOT_W'(s);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        hit_next        = 1'b0;
        read_value_next = '0;
        status_next     = ST_DONE;
        valid_row_next  = valid_row;
        row_wr_en       = 1'b0;
        wr_idx          = found ? match_idx : free_idx;
        key_wr          = key_rd;
        value_wr        = value_rd;
        key_wr[wr_idx]   = cur_reg.key;
        value_wr[wr_idx] = cur_reg.value;
        case (cur_reg.op)
            OP_INSERT:
            begin
                hit_next = found;
                if (found || free_found)
                begin
                    row_wr_en              = load_out;
                    valid_row_next[wr_idx] = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_SEARCH:
            begin
                hit_next = found;
                if (found)
                begin
                    read_value_next = value_rd[match_idx];
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_DELETE:
            begin
                hit_next = found;
                if (found)
                begin
                    valid_row_next[match_idx] = 1'b0;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg            <= 1'b1;
                valid_reg[cur_reg.bucket] <= valid_row_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_reg <= req;
        end
        if (load_out)
        begin
            hit_reg        <= hit_next;
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

>>> src/hashed_key_value_map.sv
// Hashed key-value map: bucket row memory with parallel key compare per bucket.
//
// Input channel (in_valid/in_ready): one request per handshake, carrying mode
// (0 insert or update, 1 search, 2 delete, 3 ignored), a 31-bit key and a
// 32-bit value used by insert. The key selects bucket key mod NUM_BUCKETS,
// each bucket holding SLOTS_PER_BUCKET slots.
// Output channel (out_valid/out_ready): exactly one result per request, in
// order: hit, read_value (search hit only, else zero) and status
// (0 done, 1 key not found, 2 bucket full on insert).
// The back end takes a new request only when done with the last: it reads the
// bucket row from memory in its idle state, then writes it back in its execute
// state, where it waits while the output is stalled. The result is registered
// at the end of the execute state and comes later when requests are queued ahead.
// A 2-entry request queue lets the input accept while a result waits.
// When the receiver stalls, the result register holds, the back end waits,
// and the input accepts until the queue is full.
// Reset clears all slot valid bits at once, so the map is empty right after
// reset and requests are taken as soon as reset is released.
module hashed_key_value_map
    import hkv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [KEY_W-1:0]     key,
    input  logic [VALUE_W-1:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [VALUE_W-1:0]   read_value,
    output logic [STATUS_W-1:0]  status
);

    logic      req_valid;
    logic      req_ready;
    request_t  req;

    hkv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .value     (value),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    hkv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .status     (status)
    );

endmodule

>>> dv/tb.sv
// Self-checking testbench for the hashed key-value map.
module tb;
    import hkv_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TOTAL_SLOTS    = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct {
        logic                hit;
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
    } map_result_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode = MODE_INSERT;
    logic [KEY_W-1:0]    key = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                hit;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;

    // Shadow copy of the table
    logic [KEY_W-1:0]   shadow_keys[TOTAL_SLOTS];
    logic [VALUE_W-1:0] shadow_values[TOTAL_SLOTS];
    bit                 shadow_live[TOTAL_SLOTS];

    cmd_t        pending_cmds[$];
    map_result_t expected_results[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    cmd_t        drive_cmd;
    map_result_t want;
    bit          in_fire = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          src_quiet = 1'b0;
    bit          sink_quiet = 1'b0;
    int          sent_count = 0;
    int          sink_cycles = 0;
    int          taken_count = 0;
    int          total_requests = 0;
    int          idle_cycles = 0;
    int          errors = 0;

    hashed_key_value_map DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request to the shadow table and queue the result it must give.
    function automatic void predict_map(input logic [MODE_W-1:0] m,
                                        input logic [KEY_W-1:0] k,
                                        input logic [VALUE_W-1:0] v);
        int base;
        int hit_slot;
        int free_slot;
        map_result_t r;
        base = int'(k % NUM_BUCKETS) * SLOTS_PER_BUCKET;
        hit_slot = -1;
        free_slot = -1;
        r.hit = 1'b0;
        r.read_value = '0;
        r.status = ST_DONE;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (shadow_live[base + s])
            begin
                if (hit_slot < 0 && shadow_keys[base + s] == k)
                    hit_slot = base + s;
            end
            else if (free_slot < 0)
            begin
                free_slot = base + s;
            end
        end
        case (m)
            MODE_INSERT:
            begin
                if (hit_slot >= 0)
                begin
                    shadow_values[hit_slot] = v;
                    r.hit = 1'b1;
                end
                else if (free_slot >= 0)
                begin
                    shadow_keys[free_slot] = k;
                    shadow_values[free_slot] = v;
                    shadow_live[free_slot] = 1'b1;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            MODE_SEARCH:
            begin
                if (hit_slot >= 0)
                begin
                    r.hit = 1'b1;
                    r.read_value = shadow_values[hit_slot];
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            MODE_DELETE:
            begin
                if (hit_slot >= 0)
                begin
                    shadow_live[hit_slot] = 1'b0;
                    r.hit = 1'b1;
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        expected_results.push_back(r);
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic queue_cmd(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        cmd_t c;
        c.mode = m;
        c.key = k;
        c.value = v;
        pending_cmds.push_back(c);
    endtask

    // Crowd the pool into a few buckets so they fill, overflow and drain.
    task automatic refill_pool();
        int buckets[6];
        int b;
        logic [31:0] upper;
        foreach (buckets[i])
            buckets[i] = $urandom_range(0, NUM_BUCKETS - 1);
        foreach (key_pool[i])
        begin
            b = buckets[$urandom_range(0, 5)];
            if ($urandom_range(0, 3) == 0)
                upper = $urandom_range(0, 7);
            else
                upper = ($urandom() >> 1) / NUM_BUCKETS;
            key_pool[i] = KEY_W'(upper * NUM_BUCKETS + b);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int r;
        logic [MODE_W-1:0] m;
        logic [KEY_W-1:0] k;

        // Directed: extremes, update, full bucket, lowest free slot, ignored mode
        queue_cmd(MODE_INSERT, 31'd0, 32'h7FFF_FFFF);
        queue_cmd(MODE_SEARCH, 31'd0, 32'h0);
        queue_cmd(MODE_INSERT, 31'd0, 32'h8000_0000);
        queue_cmd(MODE_SEARCH, 31'd0, 32'hFFFF_FFFF);
        queue_cmd(MODE_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(MODE_SEARCH, 31'h7FFF_FFFF, 32'h0);
        queue_cmd(MODE_INSERT, 31'd5, 32'h1234_5678);
        queue_cmd(MODE_INSERT, 31'd21, 32'hDEAD_BEEF);
        queue_cmd(MODE_INSERT, 31'd37, 32'h0000_0001);
        queue_cmd(MODE_INSERT, 31'h7FFF_FFF5, 32'hA5A5_5A5A);
        queue_cmd(MODE_INSERT, 31'd53, 32'h5555_AAAA);
        queue_cmd(MODE_SEARCH, 31'd53, 32'h0);
        queue_cmd(MODE_DELETE, 31'd21, 32'h0);
        queue_cmd(MODE_DELETE, 31'd21, 32'h0);
        queue_cmd(MODE_INSERT, 31'd53, 32'h0BAD_F00D);
        queue_cmd(MODE_SEARCH, 31'd53, 32'h0);
        queue_cmd(MODE_SEARCH, 31'd37, 32'h0);
        queue_cmd(MODE_UNUSED, 31'd5, 32'hFFFF_FFFF);
        queue_cmd(MODE_SEARCH, 31'd5, 32'h0);
        queue_cmd(MODE_DELETE, 31'h7FFF_FFFF, 32'h0);
        queue_cmd(MODE_SEARCH, 31'h7FFF_FFFF, 32'h0);
        queue_cmd(MODE_INSERT, 31'd16, 32'hCAFE_0016);
        queue_cmd(MODE_SEARCH, 31'd16, 32'h0);
        queue_cmd(MODE_SEARCH, 31'h7FFF_FFF5, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 350 == 0)
                refill_pool();
            r = $urandom_range(0, 99);
            if (r < 40)
                m = MODE_INSERT;
            else if (r < 70)
                m = MODE_SEARCH;
            else if (r < 96)
                m = MODE_DELETE;
            else
                m = MODE_UNUSED;
            if ($urandom_range(0, 9) < 8)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = KEY_W'($urandom());
            queue_cmd(m, k, pick_value());
        end
        total_requests = pending_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (taken_count < total_requests || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
            // hold until taken
        end
        else if (gap_left > 0)
        begin
            gap_left = gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (pending_cmds.size() > 0)
        begin
            drive_cmd = pending_cmds.pop_front();
            in_valid <= 1'b1;
            mode <= drive_cmd.mode;
            key <= drive_cmd.key;
            value <= drive_cmd.value;
            sent_count++;
            if (sent_count % 64 == 0)
                src_quiet = ($urandom_range(0, 3) == 0);
            gap_left = src_quiet ? 0 : pick_pause();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result sink backpressure
    always @(negedge clk)
    begin
        sink_cycles++;
        if (sink_cycles % 128 == 0)
            sink_quiet = ($urandom_range(0, 3) == 0);
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left = sink_quiet ? 0 : pick_pause();
            out_ready <= (stall_left == 0);
        end
    end

    // Monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t tb: result with nothing pending: hit %0d value %h status %0d",
                             $time, hit, read_value, status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t tb: hit mismatch, expected %0d, got %0d",
                                 $time, want.hit, hit);
                        errors++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $display("%0t tb: read_value mismatch, expected %h, got %h",
                                 $time, want.read_value, read_value);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t tb: status mismatch, expected %0d, got %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_map(mode, key, value);
                taken_count++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t tb: no handshake for %0d cycles", $time, idle_cycles);
                    $display("tb: done, errors");
                    $finish;
                end
            end
        end
    end

endmodule

>>> files.f
src/hkv_pkg.sv
src/hkv_ram.sv
src/hkv_front.sv
src/hkv_back.sv
src/hashed_key_value_map.sv
dv/tb.sv
